>>> sv/gwc_pkg.sv
`timescale 1ns / 1ps

package gwc_pkg;

  localparam int RegW  = 63;
  localparam int CompW = 21;
  localparam int IdxW  = 3;

  // register map
  localparam logic [IdxW-1:0] REG_GRAVITY   = 3'd0;
  localparam logic [IdxW-1:0] REG_LEVER     = 3'd1;
  localparam logic [IdxW-1:0] REG_FOFFSET   = 3'd2;
  localparam logic [IdxW-1:0] REG_TOFFSET   = 3'd3;
  localparam logic [IdxW-1:0] REG_MOUNT0    = 3'd4;
  localparam logic [IdxW-1:0] REG_MOUNT1    = 3'd5;
  localparam logic [IdxW-1:0] REG_MOUNT2    = 3'd6;

  // mount rotation resets to identity (Q2.18)
  localparam logic [RegW-1:0] MOUNT0_RST = 63'd1 << 18;
  localparam logic [RegW-1:0] MOUNT1_RST = 63'd1 << 39;
  localparam logic [RegW-1:0] MOUNT2_RST = 63'd1 << 60;

  localparam int SeriesLevels = 16;

  function automatic logic signed [CompW-1:0] comp21(input logic [RegW-1:0] r,
                                                     input int c);
    return $signed(r[CompW*c +: CompW]);
  endfunction

endpackage

>>> sv/gravity_wrench_compensation.sv
`timescale 1ns / 1ps
// Gravity compensation of a six-axis force/torque beat.
// The pipeline has 31 register stages (input register,
// product and norm stages, two reciprocal stages, 16 series stages, 9 matrix/vector stages, output).
// Throughput: one beat per cycle; the whole pipeline holds as one when the output stalls.
// Reset (rst_n low, synchronous): all stage valid bits clear, configuration registers take their
// reset values (zero offsets and gravity, identity mount rotation).
module gravity_wrench_compensation (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [gwc_pkg::IdxW-1:0]     cfg_index,
  input  logic [gwc_pkg::RegW-1:0]     cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [19:0]           in_rot_x,
  input  logic signed [19:0]           in_rot_y,
  input  logic signed [19:0]           in_rot_z,
  input  logic signed [23:0]           in_raw_fx,
  input  logic signed [23:0]           in_raw_fy,
  input  logic signed [23:0]           in_raw_fz,
  input  logic signed [23:0]           in_raw_tx,
  input  logic signed [23:0]           in_raw_ty,
  input  logic signed [23:0]           in_raw_tz,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [23:0]           out_comp_fx,
  output logic signed [23:0]           out_comp_fy,
  output logic signed [23:0]           out_comp_fz,
  output logic signed [23:0]           out_comp_tx,
  output logic signed [23:0]           out_comp_ty,
  output logic signed [23:0]           out_comp_tz,
  output logic                         out_clipped
);
  import gwc_pkg::*;

  // stage numbering
  localparam int ST_IN   = 0;   // input register
  localparam int ST_PROD = 1;   // v_i * v_j
  localparam int ST_T2   = 2;   // squared norm, rounded pair products
  localparam int ST_QM   = 3;   // reciprocal multiply for t2/d
  localparam int ST_QC   = 4;   // quotient correction
  localparam int ST_H0   = 5;   // first series level
  localparam int ST_HL   = ST_H0 + SeriesLevels - 1;
  localparam int ST_P1   = ST_HL + 1;  // b, products with a and b
  localparam int ST_P2   = ST_P1 + 1;  // c, rounding
  localparam int ST_P3   = ST_P2 + 1;  // R entries
  localparam int ST_P4   = ST_P3 + 1;  // R*M products
  localparam int ST_P5   = ST_P4 + 1;  // G sums
  localparam int ST_P6   = ST_P5 + 1;  // G^T*gravity products
  localparam int ST_P7   = ST_P6 + 1;  // g sums
  localparam int ST_P8   = ST_P7 + 1;  // cross products
  localparam int ST_P9   = ST_P8 + 1;  // compensation and subtraction
  localparam int ST_OUT  = ST_P9 + 1;  // saturation, output register
  localparam int NS      = ST_OUT + 1;

  localparam int RecipSh = 35;
  localparam logic signed [39:0] QONE = 40'sd1 <<< 28;
  localparam logic signed [39:0] ACC_HI = 40'sd1 <<< 31;
  localparam logic signed [39:0] ACC_LO = -(40'sd1 <<< 31);

  // ---------------- configuration ----------------
  logic [RegW-1:0] grav_r, lever_r, foff_r, toff_r;
  logic [RegW-1:0] mount_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r     <= '0;
      lever_r    <= '0;
      foff_r     <= '0;
      toff_r     <= '0;
      mount_r[0] <= MOUNT0_RST;
      mount_r[1] <= MOUNT1_RST;
      mount_r[2] <= MOUNT2_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRAVITY: grav_r     <= cfg_data;
        REG_LEVER:   lever_r    <= cfg_data;
        REG_FOFFSET: foff_r     <= cfg_data;
        REG_TOFFSET: toff_r     <= cfg_data;
        REG_MOUNT0:  mount_r[0] <= cfg_data;
        REG_MOUNT1:  mount_r[1] <= cfg_data;
        REG_MOUNT2:  mount_r[2] <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // One enable for every stage: the chain moves unless a finished beat is held.
  logic en;
  logic vld_r [NS];

  assign en       = !vld_r[ST_OUT] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < NS; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // ---------------- carried payload ----------------
  logic signed [23:0] raw_r [ST_IN:ST_P8][6];
  logic signed [19:0] v_r   [ST_IN:ST_HL][3];
  logic        [34:0] t2_r  [ST_T2:ST_HL];
  // rounded pair products, order xx yy zz xy xz yz
  logic signed [24:0] vv_r  [ST_T2:ST_HL][6];

  always_ff @(posedge clk) begin
    if (en) begin
      raw_r[ST_IN][0] <= in_raw_fx;
      raw_r[ST_IN][1] <= in_raw_fy;
      raw_r[ST_IN][2] <= in_raw_fz;
      raw_r[ST_IN][3] <= in_raw_tx;
      raw_r[ST_IN][4] <= in_raw_ty;
      raw_r[ST_IN][5] <= in_raw_tz;
      v_r[ST_IN][0]   <= in_rot_x;
      v_r[ST_IN][1]   <= in_rot_y;
      v_r[ST_IN][2]   <= in_rot_z;
      for (int s = ST_IN + 1; s <= ST_P8; s++) raw_r[s] <= raw_r[s-1];
      for (int s = ST_IN + 1; s <= ST_HL; s++) v_r[s] <= v_r[s-1];
    end
  end

  // ---------------- squared terms ----------------
  logic signed [39:0] pp_r [6];

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[0] <= v_r[ST_IN][0] * v_r[ST_IN][0];
      pp_r[1] <= v_r[ST_IN][1] * v_r[ST_IN][1];
      pp_r[2] <= v_r[ST_IN][2] * v_r[ST_IN][2];
      pp_r[3] <= v_r[ST_IN][0] * v_r[ST_IN][1];
      pp_r[4] <= v_r[ST_IN][0] * v_r[ST_IN][2];
      pp_r[5] <= v_r[ST_IN][1] * v_r[ST_IN][2];
    end
  end

  logic signed [41:0] nrm_sum;
  logic signed [41:0] nrm_rnd;

  always_comb begin
    nrm_sum = 42'(pp_r[0]) + 42'(pp_r[1]) + 42'(pp_r[2]);
    nrm_rnd = (nrm_sum + 42'sd32) >>> 6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_r[ST_T2] <= nrm_rnd[34:0];
      for (int k = 0; k < 6; k++) begin
        vv_r[ST_T2][k] <= 25'((42'(pp_r[k]) + 42'sd32768) >>> 16);
      end
      for (int s = ST_T2 + 1; s <= ST_HL; s++) begin
        t2_r[s] <= t2_r[s-1];
        vv_r[s] <= vv_r[s-1];
      end
    end
  end

  // ---------------- series coefficients q = round(t2/d) ----------------
  // lane 0: sin(t)/t, lane 1: 2(1-cos t)/t^2; level L uses n = 16-L
  logic [32:0] q_w [2][SeriesLevels];
  logic [32:0] q_r [ST_QC:ST_HL-1][2][SeriesLevels];

  for (genvar ln = 0; ln < 2; ln++) begin : g_qlane
    for (genvar lv = 0; lv < SeriesLevels; lv++) begin : g_qlev
      localparam int  NN = SeriesLevels - lv;
      localparam int  DD = (2 * NN + ln) * (2 * NN + ln + 1);
      localparam longint unsigned RM = (64'd1 << RecipSh) / DD;

      logic [35:0] num_r;
      logic [34:0] est_r;
      logic [69:0] est_prod;
      logic [35:0] num_nxt;
      logic [47:0] rem;

      always_comb begin
        num_nxt  = {1'b0, t2_r[ST_T2]} + 36'(DD / 2);
        est_prod = num_nxt * 34'(RM);
        rem      = 48'(num_r) - 48'(est_r) * 48'(DD);
      end

      assign q_w[ln][lv] = est_r[32:0] + 33'(rem >= 48'(DD));

      always_ff @(posedge clk) begin
        if (en) begin
          num_r <= num_nxt;
          est_r <= est_prod[69:RecipSh];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[ST_QC] <= q_w;
      for (int s = ST_QC + 1; s <= ST_HL - 1; s++) q_r[s] <= q_r[s-1];
    end
  end

  // ---------------- nested series, one level per stage ----------------
  logic signed [32:0] acc_r [ST_H0:ST_HL][2];

  for (genvar ln = 0; ln < 2; ln++) begin : g_hlane
    for (genvar lv = 0; lv < SeriesLevels; lv++) begin : g_hlev
      logic signed [32:0] acc_in;
      logic signed [66:0] h_prod;
      logic signed [66:0] h_rnd;
      logic signed [39:0] h_nv;
      logic signed [39:0] h_cl;

      if (lv == 0) begin : g_first
        assign acc_in = 33'(QONE);
      end else begin : g_next
        assign acc_in = acc_r[ST_H0 + lv - 1][ln];
      end

      always_comb begin
        h_prod = acc_in * $signed({1'b0, q_r[ST_H0 + lv - 1][ln][lv]});
        h_rnd  = (h_prod + (67'sd1 <<< 27)) >>> 28;
        h_nv   = QONE - h_rnd[39:0];
        if (h_nv > ACC_HI)      h_cl = ACC_HI;
        else if (h_nv < ACC_LO) h_cl = ACC_LO;
        else                    h_cl = h_nv;
      end

      always_ff @(posedge clk) begin
        if (en) acc_r[ST_H0 + lv][ln] <= h_cl[32:0];
      end
    end
  end

  // ---------------- b, products with a and b ----------------
  logic signed [32:0] b_w;
  logic signed [68:0] bt_r;
  logic signed [52:0] av_r  [3];
  logic signed [57:0] bvv_r [6];

  assign b_w = (acc_r[ST_HL][1] + 33'sd1) >>> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      bt_r <= b_w * $signed({1'b0, t2_r[ST_HL]});
      for (int k = 0; k < 3; k++) av_r[k] <= acc_r[ST_HL][0] * v_r[ST_HL][k];
      for (int k = 0; k < 6; k++) bvv_r[k] <= b_w * vv_r[ST_HL][k];
    end
  end

  // ---------------- c and rounding ----------------
  logic signed [68:0] bt_rnd;
  logic signed [41:0] c_w;
  logic signed [41:0] cq_w;
  logic signed [31:0] cq_r;
  logic signed [25:0] avr_r  [3];
  logic signed [29:0] bvvr_r [6];

  always_comb begin
    bt_rnd = (bt_r + (69'sd1 <<< 27)) >>> 28;
    c_w    = 42'(QONE) - bt_rnd[41:0];
    cq_w   = (c_w + 42'sd512) >>> 10;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cq_r <= cq_w[31:0];
      for (int k = 0; k < 3; k++) avr_r[k] <= 26'((av_r[k] + (53'sd1 <<< 26)) >>> 27);
      for (int k = 0; k < 6; k++) bvvr_r[k] <= 30'((bvv_r[k] + (58'sd1 <<< 27)) >>> 28);
    end
  end

  // ---------------- rotation matrix, Q18 ----------------
  // R = c I + a K + b v v^T; entries of a true rotation stay within +-1
  logic signed [22:0] rm_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      rm_r[0][0] <= 23'(32'(bvvr_r[0]) + cq_r);
      rm_r[1][1] <= 23'(32'(bvvr_r[1]) + cq_r);
      rm_r[2][2] <= 23'(32'(bvvr_r[2]) + cq_r);
      rm_r[0][1] <= 23'(31'(bvvr_r[3]) - 31'(avr_r[2]));
      rm_r[1][0] <= 23'(31'(bvvr_r[3]) + 31'(avr_r[2]));
      rm_r[0][2] <= 23'(31'(bvvr_r[4]) + 31'(avr_r[1]));
      rm_r[2][0] <= 23'(31'(bvvr_r[4]) - 31'(avr_r[1]));
      rm_r[1][2] <= 23'(31'(bvvr_r[5]) - 31'(avr_r[0]));
      rm_r[2][1] <= 23'(31'(bvvr_r[5]) + 31'(avr_r[0]));
    end
  end

  // ---------------- R * M ----------------
  logic signed [43:0] rmp_r [3][3][3];
  logic signed [27:0] gm_r  [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++)
            rmp_r[i][j][k] <= rm_r[i][k] * comp21(mount_r[k], j);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          gm_r[i][j] <= 28'((46'(rmp_r[i][j][0]) + 46'(rmp_r[i][j][1]) +
                             46'(rmp_r[i][j][2]) + (46'sd1 <<< 17)) >>> 18);
    end
  end

  // ---------------- gravity in sensor frame, Q18 ----------------
  logic signed [48:0] gp_r [3][3];
  logic signed [40:0] g_r  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          gp_r[i][k] <= gm_r[k][i] * comp21(grav_r, k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        g_r[i] <= 41'((51'(gp_r[i][0]) + 51'(gp_r[i][1]) + 51'(gp_r[i][2]) +
                       51'sd512) >>> 10);
    end
  end

  // ---------------- lever arm cross gravity ----------------
  // xp_r: p1g2 p2g1 p2g0 p0g2 p0g1 p1g0
  logic signed [61:0] xp_r [6];
  logic signed [34:0] fg_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      xp_r[0] <= comp21(lever_r, 1) * g_r[2];
      xp_r[1] <= comp21(lever_r, 2) * g_r[1];
      xp_r[2] <= comp21(lever_r, 2) * g_r[0];
      xp_r[3] <= comp21(lever_r, 0) * g_r[2];
      xp_r[4] <= comp21(lever_r, 0) * g_r[1];
      xp_r[5] <= comp21(lever_r, 1) * g_r[0];
      for (int i = 0; i < 3; i++) fg_r[i] <= 35'((g_r[i] + 41'sd32) >>> 6);
    end
  end

  // ---------------- subtract compensation ----------------
  logic signed [62:0] mt_w [3];
  logic signed [38:0] mr_w [3];
  logic signed [37:0] df_r [3];
  logic signed [41:0] dt_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mt_w[i] = 63'(xp_r[2*i]) - 63'(xp_r[2*i+1]);
      mr_w[i] = 39'((mt_w[i] + (63'sd1 <<< 23)) >>> 24);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        // offsets move from Q10 to Q12
        df_r[i] <= 38'(raw_r[ST_P8][i]) -
                   (38'(comp21(foff_r, i)) * 38'sd4 + 38'(fg_r[i]));
        dt_r[i] <= 42'(raw_r[ST_P8][3+i]) -
                   (42'(comp21(toff_r, i)) * 42'sd4 + 42'(mr_w[i]));
      end
    end
  end

  // ---------------- saturation, output register ----------------
  localparam logic signed [41:0] SAT_HI = 42'sd8388607;
  localparam logic signed [41:0] SAT_LO = -42'sd8388608;

  logic signed [23:0] res_w [6];
  logic               clip_w;
  logic signed [41:0] dv_w [6];

  always_comb begin
    clip_w = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dv_w[i]     = 42'(df_r[i]);
      dv_w[i + 3] = dt_r[i];
    end
    for (int i = 0; i < 6; i++) begin
      if (dv_w[i] > SAT_HI) begin
        res_w[i] = 24'(SAT_HI);
        clip_w   = 1'b1;
      end else if (dv_w[i] < SAT_LO) begin
        res_w[i] = 24'(SAT_LO);
        clip_w   = 1'b1;
      end else begin
        res_w[i] = dv_w[i][23:0];
      end
    end
  end

  logic signed [23:0] res_r [6];
  logic               clip_r;

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_w;
      clip_r <= clip_w;
    end
  end

  assign out_valid   = vld_r[ST_OUT];
  assign out_comp_fx = res_r[0];
  assign out_comp_fy = res_r[1];
  assign out_comp_fz = res_r[2];
  assign out_comp_tx = res_r[3];
  assign out_comp_ty = res_r[4];
  assign out_comp_tz = res_r[5];
  assign out_clipped = clip_r;

endmodule
